// ----- rtl/core/qs_pkg.sv -----
// shared constants and the arctangent table for the slerp datapath
package qs_pkg;

    localparam int FRAC_BITS    = 14;
    localparam int DOT_SH       = 30 - 2 * FRAC_BITS;
    localparam int CORDIC_STEPS = 30;
    localparam int XY_W         = 34;
    localparam int Q30_W        = 31;

    localparam logic [Q30_W-1:0] Q30_ONE         = 31'h4000_0000;
    localparam logic [XY_W-1:0]  CORDIC_GAIN_INV = 34'h026DD3B6A;

    function automatic logic [31:0] atan_q30(input int idx);
        case (idx)
            0:       return 32'h3243F6A8;
            1:       return 32'h1DAC6705;
            2:       return 32'h0FADBAFC;
            3:       return 32'h07F56EA6;
            4:       return 32'h03FEAB76;
            5:       return 32'h01FFD55B;
            6:       return 32'h00FFFAAA;
            7:       return 32'h007FFF55;
            8:       return 32'h003FFFEA;
            9:       return 32'h001FFFFD;
            10:      return 32'h000FFFFF;
            11:      return 32'h0007FFFF;
            12:      return 32'h0003FFFF;
            13:      return 32'h0001FFFF;
            14:      return 32'h0000FFFF;
            15:      return 32'h00007FFF;
            16:      return 32'h00003FFF;
            17:      return 32'h00001FFF;
            18:      return 32'h00000FFF;
            19:      return 32'h000007FF;
            20:      return 32'h000003FF;
            21:      return 32'h000001FF;
            22:      return 32'h000000FF;
            23:      return 32'h0000007F;
            24:      return 32'h0000003F;
            25:      return 32'h0000001F;
            26:      return 32'h0000000F;
            27:      return 32'h00000008;
            28:      return 32'h00000004;
            29:      return 32'h00000002;
            default: return 32'h00000000;
        endcase
    endfunction

endpackage

// ----- rtl/core/qs_isqrt.sv -----
// pipelined integer square root, one result bit per stage
module qs_isqrt #(
    parameter int IN_W = 62,
    parameter int SB_W = 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [IN_W-1:0]     in_rad,
    input  logic [SB_W-1:0]     in_sb,
    output logic                out_valid,
    output logic [IN_W/2-1:0]   out_root,
    output logic [SB_W-1:0]     out_sb
);
    import qs_pkg::*;

    localparam int N  = IN_W / 2;
    localparam int RW = IN_W + 1;

    logic [IN_W-1:0] rem_reg [0:N-1];
    logic [RW-1:0]   res_reg [0:N-1];
    logic            vld_reg [0:N-1];
    logic [SB_W-1:0] sb_reg  [0:N-1];

    for (genvar s = 0; s < N; s++) begin : g_stage
        logic [IN_W-1:0] rem_in, rem_next;
        logic [RW-1:0]   res_in, res_next, bit_v, trial;
        logic            v_in;
        logic [SB_W-1:0] sb_in_s;

        if (s == 0) begin : g_first
            assign rem_in  = in_rad;
            assign res_in  = '0;
            assign v_in    = in_valid;
            assign sb_in_s = in_sb;
        end else begin : g_mid
            assign rem_in  = rem_reg[s-1];
            assign res_in  = res_reg[s-1];
            assign v_in    = vld_reg[s-1];
            assign sb_in_s = sb_reg[s-1];
        end

        always_comb begin
            bit_v = RW'(1) << (IN_W - 2 - 2 * s);
            trial = res_in + bit_v;
            if ({1'b0, rem_in} >= trial) begin
                rem_next = rem_in - trial[IN_W-1:0];
                res_next = (res_in >> 1) + bit_v;
            end else begin
                rem_next = rem_in;
                res_next = res_in >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (en) begin
                vld_reg[s] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s] <= rem_next;
                res_reg[s] <= res_next;
                sb_reg[s]  <= sb_in_s;
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign out_root  = res_reg[N-1][N-1:0];
    assign out_sb    = sb_reg[N-1];

endmodule

// ----- rtl/core/qs_div.sv -----
// pipelined restoring divider, several lanes over one shared divisor
module qs_div #(
    parameter int LANES = 2,
    parameter int N_W   = 62,
    parameter int D_W   = 31,
    parameter int Q_W   = 31,
    parameter int SB_W  = 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [LANES-1:0][N_W-1:0]   in_num,
    input  logic [D_W-1:0]              in_den,
    input  logic [SB_W-1:0]             in_sb,
    output logic                        out_valid,
    output logic [LANES-1:0][Q_W-1:0]   out_quo,
    output logic [SB_W-1:0]             out_sb
);
    import qs_pkg::*;

    localparam int CW = (N_W > D_W + Q_W) ? N_W : D_W + Q_W;

    logic [LANES-1:0][CW-1:0]  rem_reg [0:Q_W-1];
    logic [LANES-1:0][Q_W-1:0] quo_reg [0:Q_W-1];
    logic [D_W-1:0]            den_reg [0:Q_W-1];
    logic                      vld_reg [0:Q_W-1];
    logic [SB_W-1:0]           sb_reg  [0:Q_W-1];

    for (genvar s = 0; s < Q_W; s++) begin : g_stage
        logic [LANES-1:0][CW-1:0]  rem_in, rem_next;
        logic [LANES-1:0][Q_W-1:0] quo_in, quo_next;
        logic [D_W-1:0]            den_in;
        logic [CW-1:0]             trial;
        logic                      v_in;
        logic [SB_W-1:0]           sb_in_s;

        if (s == 0) begin : g_first
            for (genvar l = 0; l < LANES; l++) begin : g_lane
                assign rem_in[l] = CW'(in_num[l]);
            end
            assign quo_in  = '0;
            assign den_in  = in_den;
            assign v_in    = in_valid;
            assign sb_in_s = in_sb;
        end else begin : g_mid
            assign rem_in  = rem_reg[s-1];
            assign quo_in  = quo_reg[s-1];
            assign den_in  = den_reg[s-1];
            assign v_in    = vld_reg[s-1];
            assign sb_in_s = sb_reg[s-1];
        end

        always_comb begin
            trial = CW'(den_in) << (Q_W - 1 - s);
            for (int l = 0; l < LANES; l++) begin
                if (rem_in[l] >= trial) begin
                    rem_next[l] = rem_in[l] - trial;
                    quo_next[l] = quo_in[l] | (Q_W'(1) << (Q_W - 1 - s));
                end else begin
                    rem_next[l] = rem_in[l];
                    quo_next[l] = quo_in[l];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (en) begin
                vld_reg[s] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s] <= rem_next;
                quo_reg[s] <= quo_next;
                den_reg[s] <= den_in;
                sb_reg[s]  <= sb_in_s;
            end
        end
    end

    assign out_valid = vld_reg[Q_W-1];
    assign out_quo   = quo_reg[Q_W-1];
    assign out_sb    = sb_reg[Q_W-1];

endmodule

// ----- rtl/core/qs_cordic_vec.sv -----
// pipelined cordic in vectoring mode, gives the angle of (x, y) in q30 radians
module qs_cordic_vec #(
    parameter int SB_W = 1
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [qs_pkg::Q30_W-1:0]        in_x,
    input  logic [qs_pkg::Q30_W-1:0]        in_y,
    input  logic [SB_W-1:0]                 in_sb,
    output logic                            out_valid,
    output logic signed [qs_pkg::XY_W-1:0]  out_angle,
    output logic [SB_W-1:0]                 out_sb
);
    import qs_pkg::*;

    localparam int N = CORDIC_STEPS;

    logic signed [XY_W-1:0] x_reg [0:N-1];
    logic signed [XY_W-1:0] y_reg [0:N-1];
    logic signed [XY_W-1:0] z_reg [0:N-1];
    logic                   vld_reg [0:N-1];
    logic [SB_W-1:0]        sb_reg  [0:N-1];

    for (genvar s = 0; s < N; s++) begin : g_stage
        logic signed [XY_W-1:0] x_in, y_in, z_in, x_next, y_next, z_next, at;
        logic                   v_in;
        logic [SB_W-1:0]        sb_in_s;

        if (s == 0) begin : g_first
            assign x_in    = $signed(XY_W'(in_x));
            assign y_in    = $signed(XY_W'(in_y));
            assign z_in    = '0;
            assign v_in    = in_valid;
            assign sb_in_s = in_sb;
        end else begin : g_mid
            assign x_in    = x_reg[s-1];
            assign y_in    = y_reg[s-1];
            assign z_in    = z_reg[s-1];
            assign v_in    = vld_reg[s-1];
            assign sb_in_s = sb_reg[s-1];
        end

        assign at = $signed(XY_W'(atan_q30(s)));

        // drive y toward zero, accumulating the angle turned
        always_comb begin
            if (y_in > 0) begin
                x_next = x_in + (y_in >>> s);
                y_next = y_in - (x_in >>> s);
                z_next = z_in + at;
            end else begin
                x_next = x_in - (y_in >>> s);
                y_next = y_in + (x_in >>> s);
                z_next = z_in - at;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (en) begin
                vld_reg[s] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[s]  <= x_next;
                y_reg[s]  <= y_next;
                z_reg[s]  <= z_next;
                sb_reg[s] <= sb_in_s;
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign out_angle = z_reg[N-1];
    assign out_sb    = sb_reg[N-1];

endmodule

// ----- rtl/core/qs_cordic_rot.sv -----
// pipelined cordic in rotation mode, two angles side by side, gives their sines
module qs_cordic_rot #(
    parameter int SB_W = 1
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic signed [qs_pkg::XY_W-1:0]  in_z0,
    input  logic signed [qs_pkg::XY_W-1:0]  in_z1,
    input  logic [SB_W-1:0]                 in_sb,
    output logic                            out_valid,
    output logic signed [qs_pkg::XY_W-1:0]  out_sin0,
    output logic signed [qs_pkg::XY_W-1:0]  out_sin1,
    output logic [SB_W-1:0]                 out_sb
);
    import qs_pkg::*;

    localparam int N = CORDIC_STEPS;

    logic signed [XY_W-1:0] x_reg [0:N-1][0:1];
    logic signed [XY_W-1:0] y_reg [0:N-1][0:1];
    logic signed [XY_W-1:0] z_reg [0:N-1][0:1];
    logic                   vld_reg [0:N-1];
    logic [SB_W-1:0]        sb_reg  [0:N-1];

    for (genvar s = 0; s < N; s++) begin : g_stage
        logic signed [XY_W-1:0] x_in [0:1];
        logic signed [XY_W-1:0] y_in [0:1];
        logic signed [XY_W-1:0] z_in [0:1];
        logic signed [XY_W-1:0] x_next [0:1];
        logic signed [XY_W-1:0] y_next [0:1];
        logic signed [XY_W-1:0] z_next [0:1];
        logic signed [XY_W-1:0] at;
        logic                   v_in;
        logic [SB_W-1:0]        sb_in_s;

        if (s == 0) begin : g_first
            always_comb begin
                x_in[0] = $signed(CORDIC_GAIN_INV);
                x_in[1] = $signed(CORDIC_GAIN_INV);
                y_in[0] = '0;
                y_in[1] = '0;
                z_in[0] = in_z0;
                z_in[1] = in_z1;
            end
            assign v_in    = in_valid;
            assign sb_in_s = in_sb;
        end else begin : g_mid
            always_comb begin
                x_in = x_reg[s-1];
                y_in = y_reg[s-1];
                z_in = z_reg[s-1];
            end
            assign v_in    = vld_reg[s-1];
            assign sb_in_s = sb_reg[s-1];
        end

        assign at = $signed(XY_W'(atan_q30(s)));

        always_comb begin
            for (int l = 0; l < 2; l++) begin
                if (z_in[l] >= 0) begin
                    x_next[l] = x_in[l] - (y_in[l] >>> s);
                    y_next[l] = y_in[l] + (x_in[l] >>> s);
                    z_next[l] = z_in[l] - at;
                end else begin
                    x_next[l] = x_in[l] + (y_in[l] >>> s);
                    y_next[l] = y_in[l] - (x_in[l] >>> s);
                    z_next[l] = z_in[l] + at;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (en) begin
                vld_reg[s] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[s]  <= x_next;
                y_reg[s]  <= y_next;
                z_reg[s]  <= z_next;
                sb_reg[s] <= sb_in_s;
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign out_sin0  = y_reg[N-1][0];
    assign out_sin1  = y_reg[N-1][1];
    assign out_sb    = sb_reg[N-1];

endmodule

// ----- rtl/core/quaternion_slerp.sv -----
// quaternion slerp top level: dot product, weights, weighted sum, normalization
//
//   channel   dir  signals                                   content
//   s_        in   s_tvalid s_tready s_tdata[143:0]          two quaternions and fraction
//   m_        out  m_tvalid m_tready m_tdata[63:0]           normalized quaternion
//   cfg_      in   cfg_wr_en cfg_wr_data[14:0]               linear threshold, q1.14
//
// one request per cycle unless a stall on m_tready holds the pipeline; the two square
// roots (31 and 32 stages), the two cordic passes in series (30 stages each, the sine
// pass runs both angles side by side), the two dividers (31 and 15 stages) and 15
// single register stages set the depth
// synchronous active-low reset clears the valid bits and loads the default threshold
// a stall on m_tready freezes the whole pipeline, s_tready follows it
module quaternion_slerp (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // src_x, src_y, src_z, src_w, dst_x, dst_y, dst_z, dst_w, fraction
    input  logic [143:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_x, out_y, out_z, out_w
    output logic [63:0]  m_tdata,
    input  logic         cfg_wr_en,
    input  logic [14:0]  cfg_wr_data
);
    import qs_pkg::*;

    localparam int NUM_W = Q30_W + FRAC_BITS;

    typedef struct packed {
        logic [3:0][15:0]  a;
        logic [3:0][15:0]  b;
        logic [15:0]       t;
        logic              neg;
        logic              cand;
        logic [Q30_W-1:0]  c;
    } sba_t;

    typedef struct packed {
        logic [3:0][15:0]  a;
        logic [3:0][15:0]  b;
        logic [15:0]       t;
        logic              neg;
        logic              cand;
        logic [Q30_W-1:0]  sin_w;
    } sbb_t;

    typedef struct packed {
        logic [3:0][15:0]  a;
        logic [3:0][15:0]  b;
        logic [15:0]       t;
        logic              neg;
        logic              spher;
        logic [1:0]        pos;
        logic [1:0]        sat;
    } sbc_t;

    typedef struct packed {
        logic [3:0][Q30_W-1:0] mag;
        logic [3:0]            sgn;
    } sbd_t;

    typedef struct packed {
        logic [3:0] sgn;
        logic       nz;
    } sbe_t;

    logic en;
    logic m_tvalid_reg;
    logic [14:0] thr_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= 15'd16382;
        end else if (cfg_wr_en) begin
            thr_reg <= cfg_wr_data;
        end
    end

    // stage 1: products of the dot
    logic [3:0][15:0]   a_in, b_in;
    logic [15:0]        frac_in, t_cl;
    logic               v1_reg;
    logic [3:0][15:0]   a1_reg, b1_reg;
    logic [15:0]        t1_reg;
    logic signed [31:0] p1_reg [0:3];
    logic signed [31:0] p1_next [0:3];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            a_in[i]    = s_tdata[16*i +: 16];
            b_in[i]    = s_tdata[64 + 16*i +: 16];
            p1_next[i] = $signed(a_in[i]) * $signed(b_in[i]);
        end
        frac_in = s_tdata[143:128];
        t_cl    = (frac_in > 16'd32768) ? 16'd32768 : frac_in;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a1_reg <= a_in;
            b1_reg <= b_in;
            t1_reg <= t_cl;
            p1_reg <= p1_next;
        end
    end

    // stage 2: dot, cosine, threshold compare
    logic signed [33:0] dot;
    logic [32:0]        dot_mag;
    logic [34:0]        cos30;
    logic               v2_reg;
    sba_t               sba2_reg, sba2_next;

    always_comb begin
        dot = '0;
        for (int i = 0; i < 4; i++) begin
            dot = dot + 34'(p1_reg[i]);
        end
        dot_mag         = dot[33] ? 33'(-dot) : dot[32:0];
        cos30           = 35'(dot_mag) << DOT_SH;
        sba2_next.a     = a1_reg;
        sba2_next.b     = b1_reg;
        sba2_next.t     = t1_reg;
        sba2_next.neg   = dot[33];
        sba2_next.cand  = cos30 < (35'(thr_reg) << 16);
        sba2_next.c     = (cos30 > 35'(Q30_ONE)) ? Q30_ONE : cos30[Q30_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sba2_reg <= sba2_next;
        end
    end

    // stage 3: cosine squared
    logic        v3_reg;
    sba_t        sba3_reg;
    logic [61:0] csq3_reg;
    logic [61:0] rad1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sba3_reg <= sba2_reg;
            csq3_reg <= 62'(sba2_reg.c) * 62'(sba2_reg.c);
        end
    end

    assign rad1 = (62'(1) << 60) - csq3_reg;

    // sin(w) = sqrt(1 - c^2)
    logic             sq1_valid;
    logic [30:0]      sin_w;
    logic [$bits(sba_t)-1:0] sq1_sb;
    sba_t             sba_q;

    qs_isqrt #(.IN_W(62), .SB_W($bits(sba_t))) u_sqrt_sin (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v3_reg),
        .in_rad    (rad1),
        .in_sb     (sba3_reg),
        .out_valid (sq1_valid),
        .out_root  (sin_w),
        .out_sb    (sq1_sb)
    );

    sbb_t sbb_v;

    always_comb begin
        sba_q       = sba_t'(sq1_sb);
        sbb_v.a     = sba_q.a;
        sbb_v.b     = sba_q.b;
        sbb_v.t     = sba_q.t;
        sbb_v.neg   = sba_q.neg;
        sbb_v.cand  = sba_q.cand;
        sbb_v.sin_w = sin_w;
    end

    // w = acos(c)
    logic                   vec_valid;
    logic signed [XY_W-1:0] omega;
    logic [$bits(sbb_t)-1:0] vec_sb;

    qs_cordic_vec #(.SB_W($bits(sbb_t))) u_acos (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq1_valid),
        .in_x      (sba_q.c),
        .in_y      (sin_w),
        .in_sb     (sbb_v),
        .out_valid (vec_valid),
        .out_angle (omega),
        .out_sb    (vec_sb)
    );

    // stage 4: t * w
    logic                   v4_reg;
    sbb_t                   sbb4_reg;
    logic signed [XY_W-1:0] omega4_reg, tom4_reg;
    logic signed [XY_W+16:0] tw_prod;
    sbb_t                   sbb_vec;

    always_comb begin
        sbb_vec = sbb_t'(vec_sb);
        tw_prod = $signed({1'b0, sbb_vec.t}) * omega;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= vec_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sbb4_reg   <= sbb_vec;
            omega4_reg <= omega;
            tom4_reg   <= XY_W'(tw_prod >>> 15);
        end
    end

    // sines of (1-t)w and tw
    logic                    rot_valid;
    logic signed [XY_W-1:0]  sin0, sin1;
    logic [$bits(sbb_t)-1:0] rot_sb;

    qs_cordic_rot #(.SB_W($bits(sbb_t))) u_sines (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v4_reg),
        .in_z0     (omega4_reg - tom4_reg),
        .in_z1     (tom4_reg),
        .in_sb     (sbb4_reg),
        .out_valid (rot_valid),
        .out_sin0  (sin0),
        .out_sin1  (sin1),
        .out_sb    (rot_sb)
    );

    // stage 5: division setup for the spherical weights
    logic                   v5_reg;
    sbc_t                   sbc5_reg, sbc5_next;
    logic [1:0][61:0]       num5_reg, num5_next;
    logic [Q30_W-1:0]       sinw5_reg;
    sbb_t                   sbb_rot;
    logic signed [XY_W-1:0] sin_twice;

    always_comb begin
        sbb_rot          = sbb_t'(rot_sb);
        sin_twice        = $signed(XY_W'({sbb_rot.sin_w, 1'b0}));
        sbc5_next.a      = sbb_rot.a;
        sbc5_next.b      = sbb_rot.b;
        sbc5_next.t      = sbb_rot.t;
        sbc5_next.neg    = sbb_rot.neg;
        sbc5_next.spher  = sbb_rot.cand && (sbb_rot.sin_w != '0);
        sbc5_next.pos[0] = sin0 > 0;
        sbc5_next.pos[1] = sin1 > 0;
        // quotient would pass 2^31, clamp straight away
        sbc5_next.sat[0] = sin0 >= sin_twice;
        sbc5_next.sat[1] = sin1 >= sin_twice;
        num5_next[0]     = {sin0[31:0], 30'b0};
        num5_next[1]     = {sin1[31:0], 30'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= rot_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sbc5_reg  <= sbc5_next;
            num5_reg  <= num5_next;
            sinw5_reg <= sbb_rot.sin_w;
        end
    end

    logic                    wdiv_valid;
    logic [1:0][30:0]        wquo;
    logic [$bits(sbc_t)-1:0] wdiv_sb;

    qs_div #(.LANES(2), .N_W(62), .D_W(Q30_W), .Q_W(31), .SB_W($bits(sbc_t))) u_wdiv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v5_reg),
        .in_num    (num5_reg),
        .in_den    (sinw5_reg),
        .in_sb     (sbc5_reg),
        .out_valid (wdiv_valid),
        .out_quo   (wquo),
        .out_sb    (wdiv_sb)
    );

    // stage 6: pick weights, shorter path
    logic               v6_reg;
    logic [3:0][15:0]   a6_reg, b6_reg;
    logic signed [31:0] w06_reg, w16_reg, w0_next, w1_next;
    sbc_t               sbc_w;
    logic [Q30_W-1:0]   wsph [0:1];
    logic [Q30_W-1:0]   lin0, lin1, w0u, w1u;

    always_comb begin
        sbc_w = sbc_t'(wdiv_sb);
        for (int l = 0; l < 2; l++) begin
            if (!sbc_w.pos[l]) begin
                wsph[l] = '0;
            end else if (sbc_w.sat[l] || (wquo[l] > Q30_ONE)) begin
                wsph[l] = Q30_ONE;
            end else begin
                wsph[l] = wquo[l];
            end
        end
        lin0    = Q30_W'(17'd32768 - 17'(sbc_w.t)) << 15;
        lin1    = Q30_W'(sbc_w.t) << 15;
        w0u     = sbc_w.spher ? wsph[0] : lin0;
        w1u     = sbc_w.spher ? wsph[1] : lin1;
        w0_next = $signed({1'b0, w0u});
        w1_next = sbc_w.neg ? -$signed({1'b0, w1u}) : $signed({1'b0, w1u});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (en) begin
            v6_reg <= wdiv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a6_reg  <= sbc_w.a;
            b6_reg  <= sbc_w.b;
            w06_reg <= w0_next;
            w16_reg <= w1_next;
        end
    end

    // stage 7: weighted products
    logic               v7_reg;
    logic signed [47:0] pa7_reg [0:3];
    logic signed [47:0] pb7_reg [0:3];
    logic signed [47:0] pa7_next [0:3];
    logic signed [47:0] pb7_next [0:3];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            pa7_next[i] = w06_reg * $signed(a6_reg[i]);
            pb7_next[i] = w16_reg * $signed(b6_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v7_reg <= 1'b0;
        end else if (en) begin
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pa7_reg <= pa7_next;
            pb7_reg <= pb7_next;
        end
    end

    // stage 8: weighted sum
    logic               v8_reg;
    logic signed [48:0] r8_reg [0:3];
    logic signed [48:0] r8_next [0:3];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            r8_next[i] = 49'(pa7_reg[i]) + 49'(pb7_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v8_reg <= 1'b0;
        end else if (en) begin
            v8_reg <= v7_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r8_reg <= r8_next;
        end
    end

    // stage 9: magnitudes, or-ed together give the top bit of the largest
    logic               v9_reg;
    logic signed [48:0] r9_reg [0:3];
    logic [47:0]        or9_reg, or9_next;
    logic signed [48:0] mag9;

    always_comb begin
        or9_next = '0;
        for (int i = 0; i < 4; i++) begin
            mag9     = r8_reg[i][48] ? -r8_reg[i] : r8_reg[i];
            or9_next = or9_next | mag9[47:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v9_reg <= 1'b0;
        end else if (en) begin
            v9_reg <= v8_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r9_reg  <= r8_reg;
            or9_reg <= or9_next;
        end
    end

    // stage 10: common shift so the largest fits in 30 bits
    logic               v10_reg;
    logic signed [48:0] r10_reg [0:3];
    logic [4:0]         sh10_reg, sh10_next;
    logic [5:0]         blen;

    always_comb begin
        blen = '0;
        for (int i = 0; i < 48; i++) begin
            if (or9_reg[i]) begin
                blen = 6'(i + 1);
            end
        end
        sh10_next = (blen > 6'd30) ? 5'(blen - 6'd30) : 5'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v10_reg <= 1'b0;
        end else if (en) begin
            v10_reg <= v9_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r10_reg  <= r9_reg;
            sh10_reg <= sh10_next;
        end
    end

    // stage 11: floor shift
    logic               v11_reg;
    logic signed [30:0] rs11_reg [0:3];
    logic signed [30:0] rs11_next [0:3];
    logic signed [48:0] rsh;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            rsh          = r10_reg[i] >>> sh10_reg;
            rs11_next[i] = $signed(rsh[30:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v11_reg <= 1'b0;
        end else if (en) begin
            v11_reg <= v10_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rs11_reg <= rs11_next;
        end
    end

    // stage 12: squares
    logic               v12_reg;
    logic [60:0]        sq12_reg [0:3];
    logic [60:0]        sq12_next [0:3];
    sbd_t               sbd12_reg, sbd12_next;
    logic signed [61:0] sq_full;
    logic signed [30:0] rabs;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            sq_full              = rs11_reg[i] * rs11_reg[i];
            sq12_next[i]         = sq_full[60:0];
            rabs                 = rs11_reg[i][30] ? -rs11_reg[i] : rs11_reg[i];
            sbd12_next.mag[i]    = rabs;
            sbd12_next.sgn[i]    = rs11_reg[i][30];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v12_reg <= 1'b0;
        end else if (en) begin
            v12_reg <= v11_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq12_reg  <= sq12_next;
            sbd12_reg <= sbd12_next;
        end
    end

    // stage 13: sum of squares
    logic        v13_reg;
    logic [63:0] n2_13_reg, n2_next;
    sbd_t        sbd13_reg;

    always_comb begin
        n2_next = '0;
        for (int i = 0; i < 4; i++) begin
            n2_next = n2_next + 64'(sq12_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v13_reg <= 1'b0;
        end else if (en) begin
            v13_reg <= v12_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n2_13_reg <= n2_next;
            sbd13_reg <= sbd12_reg;
        end
    end

    logic                    sq2_valid;
    logic [31:0]             norm;
    logic [$bits(sbd_t)-1:0] sq2_sb;

    qs_isqrt #(.IN_W(64), .SB_W($bits(sbd_t))) u_sqrt_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v13_reg),
        .in_rad    (n2_13_reg),
        .in_sb     (sbd13_reg),
        .out_valid (sq2_valid),
        .out_root  (norm),
        .out_sb    (sq2_sb)
    );

    // stage 14: rounded numerators
    logic                   v14_reg;
    logic [3:0][NUM_W-1:0]  num14_reg, num14_next;
    logic [31:0]            n14_reg;
    sbe_t                   sbe14_reg, sbe14_next;
    sbd_t                   sbd_n;

    always_comb begin
        sbd_n = sbd_t'(sq2_sb);
        for (int i = 0; i < 4; i++) begin
            num14_next[i] = (NUM_W'(sbd_n.mag[i]) << FRAC_BITS) + NUM_W'(norm >> 1);
        end
        sbe14_next.sgn = sbd_n.sgn;
        sbe14_next.nz  = norm != '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v14_reg <= 1'b0;
        end else if (en) begin
            v14_reg <= sq2_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num14_reg <= num14_next;
            n14_reg   <= norm;
            sbe14_reg <= sbe14_next;
        end
    end

    logic                        ndiv_valid;
    logic [3:0][FRAC_BITS:0]     nquo;
    logic [$bits(sbe_t)-1:0]     ndiv_sb;

    qs_div #(
        .LANES (4),
        .N_W   (NUM_W),
        .D_W   (32),
        .Q_W   (FRAC_BITS + 1),
        .SB_W  ($bits(sbe_t))
    ) u_ndiv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v14_reg),
        .in_num    (num14_reg),
        .in_den    (n14_reg),
        .in_sb     (sbe14_reg),
        .out_valid (ndiv_valid),
        .out_quo   (nquo),
        .out_sb    (ndiv_sb)
    );

    // output register
    logic [63:0] m_tdata_reg, m_tdata_next;
    sbe_t        sbe_o;
    logic [FRAC_BITS:0] qc;

    always_comb begin
        sbe_o = sbe_t'(ndiv_sb);
        for (int i = 0; i < 4; i++) begin
            qc = (nquo[i] > (FRAC_BITS + 1)'(1 << FRAC_BITS)) ?
                 (FRAC_BITS + 1)'(1 << FRAC_BITS) : nquo[i];
            if (!sbe_o.nz) begin
                m_tdata_next[16*i +: 16] = '0;
            end else if (sbe_o.sgn[i]) begin
                m_tdata_next[16*i +: 16] = -16'(qc);
            end else begin
                m_tdata_next[16*i +: 16] = 16'(qc);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= ndiv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- rtl/core/qs_checker.sv -----
// port-level checks for the slerp block and their bind
module qs_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [63:0]  m_tdata
);

    // a held result keeps its data
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // nothing comes out right after reset
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // an empty output stage never blocks requests
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

    // normalized components stay within +-1.0
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |->
            ($signed(m_tdata[15:0])  <= 16384) && ($signed(m_tdata[15:0])  >= -16384) &&
            ($signed(m_tdata[31:16]) <= 16384) && ($signed(m_tdata[31:16]) >= -16384) &&
            ($signed(m_tdata[47:32]) <= 16384) && ($signed(m_tdata[47:32]) >= -16384) &&
            ($signed(m_tdata[63:48]) <= 16384) && ($signed(m_tdata[63:48]) >= -16384))
        else $error("component out of range");

endmodule

bind quaternion_slerp qs_checker u_qs_checker (.*);
